[hdl/tcce_pkg.sv]
// ----------------------------------------------------------------------------
// tcce_pkg - shared types and constants of the text console cursor engine
// Character codes, grid command format and default geometry.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // Default grid geometry
    localparam int COLUMNS_DEF    = 71;
    localparam int BOTTOM_ROW_DEF = 28;

    // Fixed widths of the command fields
    localparam int CODE_W     = 8;
    localparam int CELL_COL_W = 7;
    localparam int CELL_ROW_W = 5;
    localparam int LINES_W    = 2;

    // Tab stops fall on multiples of 8
    localparam int TAB_STOP_BITS = 3;

    // Character codes
    localparam logic [CODE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CODE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CODE_W-1:0] CH_QMARK = 8'h3F;
    localparam logic [CODE_W-1:0] CH_TILDE = 8'h7E;

    typedef enum logic [0:0] {
        CMD_WRITE  = 1'b0,
        CMD_SCROLL = 1'b1
    } cmd_kind_t;

    // One grid command
    typedef struct packed {
        cmd_kind_t              kind;
        logic [CELL_COL_W-1:0]  column;
        logic [CELL_ROW_W-1:0]  row;
        logic [CODE_W-1:0]      code;
        logic [LINES_W-1:0]     lines;
        logic                   last;
    } cmd_t;

    // Outcome of one step of the cursor engine
    typedef struct packed {
        logic has_cmd;   // the step produces a grid command
        logic done;      // the character is fully consumed after this step
        cmd_t cmd;
    } step_t;

endpackage

[hdl/tcce_step.sv]
// ----------------------------------------------------------------------------
// tcce_step - one step of the cursor engine
// Given the character in work and the cursor, produces at most one grid
// command and the cursor after it. Purely combinational.
// ----------------------------------------------------------------------------
module tcce_step
    import tcce_pkg::*;
#(
    parameter int COLUMNS    = COLUMNS_DEF,
    parameter int BOTTOM_ROW = BOTTOM_ROW_DEF,
    parameter int COL_W      = $clog2(COLUMNS + 1),
    parameter int ROW_W      = $clog2(BOTTOM_ROW + 3)
) (
    input  logic [CODE_W-1:0] character,
    input  logic [COL_W-1:0]  col,
    input  logic [ROW_W-1:0]  row,
    output logic [COL_W-1:0]  col_next,
    output logic [ROW_W-1:0]  row_next,
    output step_t             step
);

    localparam logic [ROW_W-1:0] BOTTOM  = ROW_W'(BOTTOM_ROW);
    localparam logic [COL_W-1:0] COL_END = COL_W'(COLUMNS);

    logic [ROW_W-1:0] row_inc;
    logic [COL_W-1:0] col_inc;
    logic [ROW_W-1:0] excess;
    logic [ROW_W-1:0] nl_excess;
    logic [CODE_W-1:0] write_code;
    logic              unprintable;

    assign row_inc   = row + ROW_W'(1);
    assign col_inc   = col + COL_W'(1);
    assign excess    = row - BOTTOM;
    assign nl_excess = row_inc - BOTTOM;

    // Map control and high codes to a question mark; tabs write spaces
    assign unprintable = ((character != CH_NUL) && (character < CH_SPACE)) ||
                         (character > CH_TILDE);
    always_comb begin
        if (character == CH_TAB) begin
            write_code = CH_SPACE;
        end else if (unprintable) begin
            write_code = CH_QMARK;
        end else begin
            write_code = character;
        end
    end

    // Pick scroll, write or nothing for this step
    always_comb begin
        col_next         = col;
        row_next         = row;
        step.has_cmd     = 1'b0;
        step.done        = 1'b1;
        step.cmd.kind    = CMD_WRITE;
        step.cmd.column  = '0;
        step.cmd.row     = '0;
        step.cmd.code    = '0;
        step.cmd.lines   = '0;

        if (character == CH_NUL) begin
            // drop: no command, cursor holds
        end else if (character == CH_LF) begin
            col_next = '0;
            if (row_inc > BOTTOM) begin
                step.has_cmd   = 1'b1;
                step.cmd.kind  = CMD_SCROLL;
                step.cmd.lines = LINES_W'(nl_excess);
                row_next       = BOTTOM;
            end else begin
                row_next = row_inc;
            end
        end else if (row > BOTTOM) begin
            // scroll left over from a wrap comes before the write
            step.has_cmd   = 1'b1;
            step.done      = 1'b0;
            step.cmd.kind  = CMD_SCROLL;
            step.cmd.lines = LINES_W'(excess);
            row_next       = BOTTOM;
        end else begin
            step.has_cmd    = 1'b1;
            step.cmd.kind   = CMD_WRITE;
            step.cmd.column = CELL_COL_W'(col);
            step.cmd.row    = CELL_ROW_W'(row);
            step.cmd.code   = write_code;
            if (col_inc >= COL_END) begin
                col_next = '0;
                row_next = row_inc;
            end else begin
                col_next = col_inc;
            end
            if (character == CH_TAB) begin
                step.done = (col_next[TAB_STOP_BITS-1:0] == '0);
            end
        end

        step.cmd.last = step.done;
    end

endmodule

[hdl/text_console_cursor_engine_core.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_engine_core - text console cursor engine
// Takes one character per request, tracks the cursor and issues write-cell
// and scroll-up commands for an external character grid.
// ----------------------------------------------------------------------------
//
//  Port group     | Direction | Handshake          | Payload
//  ---------------+-----------+--------------------+-----------------------------
//  s_*            | in        | s_valid / s_ready  | s_character
//  m_*            | out       | m_valid / m_ready  | command, cell, lines, last
//  cfg_*          | in        | cfg_we (no wait)   | cfg_wdata (console enabled)
//
//  A character sits in the work register and advances one step per cycle,
//  unless its command finds the result register full. Each step gives at
//  most one command: a printable character gives one write, after a scroll
//  if one is pending, and a tab up to 8 writes (one per space), likewise.
//  The next character is taken in the cycle the current one finishes.
//  A stalled result register holds the work step that would emit a command.
//  Reset is synchronous, active low; it clears the cursor, the enable and
//  both valid flags.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_core
    import tcce_pkg::*;
#(
    parameter int COLUMNS    = COLUMNS_DEF,
    parameter int BOTTOM_ROW = BOTTOM_ROW_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic                  cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CODE_W-1:0]     s_character,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_command_kind,
    output logic [CELL_COL_W-1:0] m_cell_column,
    output logic [CELL_ROW_W-1:0] m_cell_row,
    output logic [CODE_W-1:0]     m_cell_code,
    output logic [LINES_W-1:0]    m_scroll_lines,
    output logic                  m_last_of_run
);

    localparam int COL_W = $clog2(COLUMNS + 1);
    localparam int ROW_W = $clog2(BOTTOM_ROW + 3);

    logic              enabled_reg;
    logic              work_valid_reg;
    logic [CODE_W-1:0] work_char_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              m_valid_reg;
    cmd_t              cmd_reg;

    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_next;
    step_t             step;
    logic              out_free;
    logic              emit;
    logic              step_go;
    logic              s_take;

    tcce_step #(
        .COLUMNS    (COLUMNS),
        .BOTTOM_ROW (BOTTOM_ROW),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W)
    ) u_step (
        .character (work_char_reg),
        .col       (col_reg),
        .row       (row_reg),
        .col_next  (col_next),
        .row_next  (row_next),
        .step      (step)
    );

    // Advance a step when its command, if any, has room in the result register
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = step.has_cmd && enabled_reg;
    assign step_go  = work_valid_reg && (!emit || out_free);
    assign s_ready  = !work_valid_reg || (step_go && step.done);
    assign s_take   = s_valid && s_ready;

    // Hold configuration, work item, cursor and result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg    <= 1'b0;
            work_valid_reg <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                enabled_reg <= cfg_wdata;
            end

            if (s_take) begin
                work_valid_reg <= 1'b1;
            end else if (step_go && step.done) begin
                work_valid_reg <= 1'b0;
            end

            if (step_go) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end

            if (step_go && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Load payloads without reset
    always_ff @(posedge aclk) begin
        if (s_take) begin
            work_char_reg <= s_character;
        end
        if (step_go && emit) begin
            cmd_reg <= step.cmd;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_command_kind = cmd_reg.kind;
    assign m_cell_column  = cmd_reg.column;
    assign m_cell_row     = cmd_reg.row;
    assign m_cell_code    = cmd_reg.code;
    assign m_scroll_lines = cmd_reg.lines;
    assign m_last_of_run  = cmd_reg.last;

    // Cursor stays within the grid, at most one row past the bottom
    assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg < COL_W'(COLUMNS)) && (row_reg <= ROW_W'(BOTTOM_ROW + 1)))
        else $error("cursor out of range");

    // A scroll moves one or two lines and carries no cell
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (cmd_reg.kind == CMD_SCROLL)) |->
        ((cmd_reg.lines == LINES_W'(1)) || (cmd_reg.lines == LINES_W'(2))) &&
        (cmd_reg.column == '0) && (cmd_reg.row == '0) && (cmd_reg.code == '0))
        else $error("malformed scroll command");

    // A write lands on the grid and scrolls nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (cmd_reg.kind == CMD_WRITE)) |->
        (cmd_reg.lines == '0) && (cmd_reg.row <= CELL_ROW_W'(BOTTOM_ROW)) &&
        (cmd_reg.column < CELL_COL_W'(COLUMNS)))
        else $error("malformed write command");

    // A scroll that does not finish its character leaves that character in work
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (cmd_reg.kind == CMD_SCROLL) && !cmd_reg.last) |->
        work_valid_reg)
        else $error("scroll issued without a following write");

    // With the console detached no command appears
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!enabled_reg && !m_valid_reg && !cfg_we) |=> !m_valid_reg)
        else $error("command issued while console detached");

endmodule

[dv/tb_text_console_cursor_engine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_engine_core - self-checking bench of the cursor engine
// Feeds characters through the request channel under bursty pacing and a
// randomly stalling command receiver. A cursor tracker in the bench predicts
// every grid command (writes, scrolls, last-of-run flag), and each command
// that leaves the block is compared field by field. A short table of
// hand-picked characters runs first, then random text with long lines,
// tabs, blank lines and noise, with the grid attached and detached.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_engine_core;
    import tcce_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 500000;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_MOSTLY,
        RX_SPARSE
    } rx_mode_t;

    // One row of the hand-picked character table
    typedef struct {
        logic [CODE_W-1:0] ch;
        bit                typed;
        bit                has_cmd;
        cmd_t              cmd;
    } char_case_t;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic                  cfg_wdata   = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [CODE_W-1:0]     s_character = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic                  m_command_kind;
    logic [CELL_COL_W-1:0] m_cell_column;
    logic [CELL_ROW_W-1:0] m_cell_row;
    logic [CODE_W-1:0]     m_cell_code;
    logic [LINES_W-1:0]    m_scroll_lines;
    logic                  m_last_of_run;

    // Cursor tracker state
    bit                    grid_on;
    logic [CELL_COL_W-1:0] cur_col;
    logic [CELL_ROW_W-1:0] cur_row;
    cmd_t                  run_cmds[$];
    cmd_t                  grid_cmds_due[$];

    logic [CODE_W-1:0]     text_run[$];
    char_case_t            char_cases[$];
    int                    burst_left;
    int                    error_count;
    int                    cycle_count;
    bit                    hold_off_req;
    int                    hold_left;
    rx_mode_t              rx_mode;
    int                    mode_left;

    text_console_cursor_engine_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_character    (s_character),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_command_kind (m_command_kind),
        .m_cell_column  (m_cell_column),
        .m_cell_row     (m_cell_row),
        .m_cell_code    (m_cell_code),
        .m_scroll_lines (m_scroll_lines),
        .m_last_of_run  (m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Cursor tracker
    // ------------------------------------------------------------------
    function automatic cmd_t wr_cell(int col, int row, logic [CODE_W-1:0] code);
        cmd_t c;
        c        = '0;
        c.kind   = CMD_WRITE;
        c.column = col[CELL_COL_W-1:0];
        c.row    = row[CELL_ROW_W-1:0];
        c.code   = code;
        c.last   = 1'b1;
        return c;
    endfunction

    // Scroll off any rows past the bottom before touching the grid
    task automatic settle_row();
        cmd_t c;
        if (cur_row > CELL_ROW_W'(BOTTOM_ROW_DEF)) begin
            c       = '0;
            c.kind  = CMD_SCROLL;
            c.lines = LINES_W'(cur_row - BOTTOM_ROW_DEF);
            if (grid_on) run_cmds.push_back(c);
            cur_row = CELL_ROW_W'(BOTTOM_ROW_DEF);
        end
    endtask

    // Write one cell and advance, wrapping at the right edge
    task automatic write_cell(input logic [CODE_W-1:0] ch);
        cmd_t c;
        c        = '0;
        c.kind   = CMD_WRITE;
        c.column = cur_col;
        c.row    = cur_row;
        c.code   = ((ch > CH_NUL && ch < CH_SPACE) || ch > CH_TILDE) ? CH_QMARK : ch;
        if (grid_on) run_cmds.push_back(c);
        cur_col = cur_col + CELL_COL_W'(1);
        if (cur_col >= CELL_COL_W'(COLUMNS_DEF)) begin
            cur_col = '0;
            cur_row = cur_row + CELL_ROW_W'(1);
        end
    endtask

    // Work out the grid commands one character causes
    task automatic advance_cursor(input logic [CODE_W-1:0] ch);
        run_cmds.delete();
        if (ch == CH_TAB) begin
            do begin
                settle_row();
                write_cell(CH_SPACE);
            end while (cur_col[TAB_STOP_BITS-1:0] != '0);
        end else if (ch == CH_LF) begin
            cur_row = cur_row + CELL_ROW_W'(1);
            cur_col = '0;
            settle_row();
        end else if (ch != CH_NUL) begin
            settle_row();
            write_cell(ch);
        end
        if (run_cmds.size() > 0) run_cmds[run_cmds.size()-1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Offer one character, hold it until taken, then book its commands
    task automatic push_char(input logic [CODE_W-1:0] ch, input bit typed,
                             input bit has_cmd, input cmd_t cmd);
        s_valid     <= 1'b1;
        s_character <= ch;
        do @(posedge aclk); while (!(s_valid && s_ready));
        advance_cursor(ch);
        if (typed) begin
            if (has_cmd && grid_on) grid_cmds_due.push_back(cmd);
        end else begin
            foreach (run_cmds[i]) grid_cmds_due.push_back(run_cmds[i]);
        end
    endtask

    // Send in bursts, with a random gap between bursts
    task automatic send_paced(input logic [CODE_W-1:0] ch, input bit typed,
                              input bit has_cmd, input cmd_t cmd);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        push_char(ch, typed, has_cmd, cmd);
    endtask

    // Stop sending, wait out every pending command and the engine's tail
    task automatic drain_requests();
        s_valid <= 1'b0;
        while (grid_cmds_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_enable(input logic en);
        cfg_we    <= 1'b1;
        cfg_wdata <= en;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        grid_on   = en;
    endtask

    function automatic logic [CODE_W-1:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return CODE_W'($urandom_range(CH_SPACE, CH_TILDE));
        if (r < 80) return CODE_W'($urandom_range(CH_TILDE + 1, 255));
        if (r < 88) return CH_TAB;
        if (r < 93) return CODE_W'($urandom_range(1, CH_SPACE - 1));
        return CODE_W'($urandom_range(0, 255));
    endfunction

    // Queue up one stretch of text: a line, blank lines, a line that fills
    // exactly to the wrap, a control burst, or raw noise
    task automatic build_text_run(input bit lf_heavy);
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (lf_heavy && pick < 50) pick = 45;
        if (pick < 40) begin
            n = $urandom_range(0, 20);
            repeat (n) text_run.push_back(random_char());
            text_run.push_back(CH_LF);
        end else if (pick < 55) begin
            repeat ($urandom_range(1, 6)) text_run.push_back(CH_LF);
        end else if (pick < 75) begin
            n = COLUMNS_DEF - int'(cur_col);
            repeat (n) begin
                if ($urandom_range(0, 9) == 0)
                    text_run.push_back(CODE_W'($urandom_range(CH_TILDE + 1, 255)));
                else
                    text_run.push_back(CODE_W'($urandom_range(CH_SPACE + 1, CH_TILDE)));
            end
            case ($urandom_range(0, 2))
                0: text_run.push_back(CH_LF);
                1: text_run.push_back(CH_TAB);
                default: text_run.push_back(CODE_W'($urandom_range(CH_SPACE, CH_TILDE)));
            endcase
        end else if (pick < 90) begin
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(0, 3))
                    0: text_run.push_back(CH_TAB);
                    1: text_run.push_back(CH_LF);
                    2: text_run.push_back(CH_NUL);
                    default: text_run.push_back(CODE_W'($urandom_range(1, CH_SPACE - 1)));
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 16)) text_run.push_back(CODE_W'($urandom_range(0, 255)));
        end
    endtask

    // Send random text until enough characters have been taken
    task automatic run_random(input int n_chars, input bit lf_heavy);
        int sent;
        logic [CODE_W-1:0] ch;
        sent = 0;
        while (sent < n_chars) begin
            if (text_run.size() == 0) build_text_run(lf_heavy);
            ch = text_run.pop_front();
            send_paced(ch, 1'b0, 1'b0, '0);
            if (ch != CH_NUL) sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Command side: check, then pick the next ready
    // ------------------------------------------------------------------
    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            error_count++;
        end
    endtask

    task automatic check_grid_cmd();
        cmd_t e;
        if (grid_cmds_due.size() == 0) begin
            $display("%0t ns: unexpected command, kind %0d col %0d row %0d code %0d lines %0d",
                     $time, m_command_kind, m_cell_column, m_cell_row, m_cell_code,
                     m_scroll_lines);
            error_count++;
        end else begin
            e = grid_cmds_due.pop_front();
            check_field("command_kind", 8'(e.kind), 8'(m_command_kind));
            check_field("cell_column", 8'(e.column), 8'(m_cell_column));
            check_field("cell_row", 8'(e.row), 8'(m_cell_row));
            check_field("cell_code", e.code, m_cell_code);
            check_field("scroll_lines", 8'(e.lines), 8'(m_scroll_lines));
            check_field("last_of_run", 8'(e.last), 8'(m_last_of_run));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_grid_cmd();
        // Long hold-off on request, counted here
        if (hold_off_req) begin
            hold_left    = HOLD_CYCLES;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 80);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                default:   m_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        grid_on = 1'b0;
        cur_col = '0;
        cur_row = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_enable(1'b1);

        // Hand-picked characters: sanitizing, tabs, NUL, newline
        char_cases.push_back('{8'h41,    1'b1, 1'b1, wr_cell(0, 0, 8'h41)});
        char_cases.push_back('{8'hFF,    1'b1, 1'b1, wr_cell(1, 0, CH_QMARK)});
        char_cases.push_back('{8'h7F,    1'b1, 1'b1, wr_cell(2, 0, CH_QMARK)});
        char_cases.push_back('{8'h01,    1'b1, 1'b1, wr_cell(3, 0, CH_QMARK)});
        char_cases.push_back('{8'h1F,    1'b1, 1'b1, wr_cell(4, 0, CH_QMARK)});
        char_cases.push_back('{CH_TILDE, 1'b1, 1'b1, wr_cell(5, 0, CH_TILDE)});
        char_cases.push_back('{CH_SPACE, 1'b1, 1'b1, wr_cell(6, 0, CH_SPACE)});
        char_cases.push_back('{CH_NUL,   1'b1, 1'b0, '0});
        char_cases.push_back('{CH_TAB,   1'b1, 1'b1, wr_cell(7, 0, CH_SPACE)});
        char_cases.push_back('{CH_TAB,   1'b0, 1'b0, '0});
        char_cases.push_back('{CH_LF,    1'b1, 1'b0, '0});
        char_cases.push_back('{8'h80,    1'b1, 1'b1, wr_cell(0, 1, CH_QMARK)});
        char_cases.push_back('{8'h08,    1'b1, 1'b1, wr_cell(1, 1, CH_QMARK)});
        char_cases.push_back('{8'h0B,    1'b1, 1'b1, wr_cell(2, 1, CH_QMARK)});
        char_cases.push_back('{8'h0D,    1'b1, 1'b1, wr_cell(3, 1, CH_QMARK)});
        char_cases.push_back('{8'h30,    1'b1, 1'b1, wr_cell(4, 1, 8'h30)});
        char_cases.push_back('{8'h5A,    1'b0, 1'b0, '0});
        char_cases.push_back('{CH_TAB,   1'b0, 1'b0, '0});
        foreach (char_cases[i])
            send_paced(char_cases[i].ch, char_cases[i].typed, char_cases[i].has_cmd,
                       char_cases[i].cmd);
        drain_requests();

        // Grid attached; receiver holds off so the engine backs up
        hold_off_req = 1'b1;
        run_random(75, 1'b0);
        drain_requests();
        run_random(75, 1'b0);
        drain_requests();

        // Grid detached: cursor keeps moving, nothing comes out
        write_enable(1'b0);
        run_random(60, 1'b1);
        drain_requests();

        // Attached again, cursor pinned at the bottom row
        write_enable(1'b1);
        hold_off_req = 1'b1;
        run_random(130, 1'b0);
        drain_requests();

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
